// ===== design/bcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcsc_pkg: shared types and constants of the charge stage controller
// Stage and event codes, register map, the configuration bundle and the
// controller state bundle used between the register file, the stage logic
// and the top level.
// ----------------------------------------------------------------------------
package bcsc_pkg;

    // Field widths
    localparam int VOLT_W   = 13;
    localparam int CUR_W    = 10;
    localparam int MODE_W   = 3;
    localparam int MS_W     = 16;
    localparam int TIME_W   = 32;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 5;
    localparam int REG_IDX_W = 3;

    // Charging stages
    typedef enum logic [2:0] {
        ST_OFF    = 3'd0,
        ST_READY  = 3'd1,
        ST_PRE    = 3'd2,
        ST_FAST   = 3'd3,
        ST_NORMAL = 3'd4,
        ST_CV     = 3'd5,
        ST_BAL    = 3'd6,
        ST_MAINT  = 3'd7
    } t_stage;

    // Event codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_EVAL = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TICK = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ON   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OFF  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FULL = 3'd4;
    localparam logic [MODE_W-1:0] MODE_HIGH = 3'd5;

    // Register indexes (byte address is 4 times the index)
    localparam logic [REG_IDX_W-1:0] REG_PRE_THR  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FAST_THR = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CV_THR   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PRE_CUR  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FAST_CUR = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_NORM_CUR = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BAL_CUR  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_BAL_DUR  = 3'd7;

    // Register reset values
    localparam logic [VOLT_W-1:0] RST_PRE_THR  = 13'd3360;
    localparam logic [VOLT_W-1:0] RST_FAST_THR = 13'd4100;
    localparam logic [VOLT_W-1:0] RST_CV_THR   = 13'd4350;
    localparam logic [CUR_W-1:0]  RST_PRE_CUR  = 10'd7;
    localparam logic [CUR_W-1:0]  RST_FAST_CUR = 10'd50;
    localparam logic [CUR_W-1:0]  RST_NORM_CUR = 10'd20;
    localparam logic [CUR_W-1:0]  RST_BAL_CUR  = 10'd6;
    localparam logic [TIME_W-1:0] RST_BAL_DUR  = 32'd1800000;

    // Configuration bundle
    typedef struct packed {
        logic [VOLT_W-1:0] pre_thr;
        logic [VOLT_W-1:0] fast_thr;
        logic [VOLT_W-1:0] cv_thr;
        logic [CUR_W-1:0]  pre_cur;
        logic [CUR_W-1:0]  fast_cur;
        logic [CUR_W-1:0]  norm_cur;
        logic [CUR_W-1:0]  bal_cur;
        logic [TIME_W-1:0] bal_dur;
    } t_cfg;

    // Controller state bundle
    typedef struct packed {
        t_stage            stage;
        logic [CUR_W-1:0]  current;
        logic [TIME_W-1:0] time_ms;
        logic [TIME_W-1:0] bal_start;
    } t_ctrl_state;

endpackage

// ===== design/bcsc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bcsc_cfg_regs: configuration register file
// APB-style slave holding the thresholds, currents and balancing time.
// Writes complete in the access phase; reads return the stored value.
// ----------------------------------------------------------------------------
module bcsc_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bcsc_pkg::APB_AW-1:0] paddr,
    input  logic [bcsc_pkg::APB_DW-1:0] pwdata,
    output logic [bcsc_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output bcsc_pkg::t_cfg              o_cfg
);

    bcsc_pkg::t_cfg                   r_cfg;
    logic                             w_wr;
    logic [bcsc_pkg::REG_IDX_W-1:0]   w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[bcsc_pkg::APB_AW-1:2];
    assign o_cfg  = r_cfg;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pre_thr  <= bcsc_pkg::RST_PRE_THR;
            r_cfg.fast_thr <= bcsc_pkg::RST_FAST_THR;
            r_cfg.cv_thr   <= bcsc_pkg::RST_CV_THR;
            r_cfg.pre_cur  <= bcsc_pkg::RST_PRE_CUR;
            r_cfg.fast_cur <= bcsc_pkg::RST_FAST_CUR;
            r_cfg.norm_cur <= bcsc_pkg::RST_NORM_CUR;
            r_cfg.bal_cur  <= bcsc_pkg::RST_BAL_CUR;
            r_cfg.bal_dur  <= bcsc_pkg::RST_BAL_DUR;
        end else if (w_wr) begin
            unique case (w_idx)
                bcsc_pkg::REG_PRE_THR:  r_cfg.pre_thr  <= pwdata[bcsc_pkg::VOLT_W-1:0];
                bcsc_pkg::REG_FAST_THR: r_cfg.fast_thr <= pwdata[bcsc_pkg::VOLT_W-1:0];
                bcsc_pkg::REG_CV_THR:   r_cfg.cv_thr   <= pwdata[bcsc_pkg::VOLT_W-1:0];
                bcsc_pkg::REG_PRE_CUR:  r_cfg.pre_cur  <= pwdata[bcsc_pkg::CUR_W-1:0];
                bcsc_pkg::REG_FAST_CUR: r_cfg.fast_cur <= pwdata[bcsc_pkg::CUR_W-1:0];
                bcsc_pkg::REG_NORM_CUR: r_cfg.norm_cur <= pwdata[bcsc_pkg::CUR_W-1:0];
                bcsc_pkg::REG_BAL_CUR:  r_cfg.bal_cur  <= pwdata[bcsc_pkg::CUR_W-1:0];
                bcsc_pkg::REG_BAL_DUR:  r_cfg.bal_dur  <= pwdata[bcsc_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register, zero-extended
    always_comb begin
        unique case (w_idx)
            bcsc_pkg::REG_PRE_THR:  prdata = {{(bcsc_pkg::APB_DW-bcsc_pkg::VOLT_W){1'b0}},
                                              r_cfg.pre_thr};
            bcsc_pkg::REG_FAST_THR: prdata = {{(bcsc_pkg::APB_DW-bcsc_pkg::VOLT_W){1'b0}},
                                              r_cfg.fast_thr};
            bcsc_pkg::REG_CV_THR:   prdata = {{(bcsc_pkg::APB_DW-bcsc_pkg::VOLT_W){1'b0}},
                                              r_cfg.cv_thr};
            bcsc_pkg::REG_PRE_CUR:  prdata = {{(bcsc_pkg::APB_DW-bcsc_pkg::CUR_W){1'b0}},
                                              r_cfg.pre_cur};
            bcsc_pkg::REG_FAST_CUR: prdata = {{(bcsc_pkg::APB_DW-bcsc_pkg::CUR_W){1'b0}},
                                              r_cfg.fast_cur};
            bcsc_pkg::REG_NORM_CUR: prdata = {{(bcsc_pkg::APB_DW-bcsc_pkg::CUR_W){1'b0}},
                                              r_cfg.norm_cur};
            bcsc_pkg::REG_BAL_CUR:  prdata = {{(bcsc_pkg::APB_DW-bcsc_pkg::CUR_W){1'b0}},
                                              r_cfg.bal_cur};
            bcsc_pkg::REG_BAL_DUR:  prdata = r_cfg.bal_dur;
            default:                prdata = '0;
        endcase
    end

endmodule

// ===== design/bcsc_stage_logic.sv =====
// ----------------------------------------------------------------------------
// bcsc_stage_logic: next-state logic of the charge controller
// Applies one event to the present stage, current, clock and balancing
// start time, and returns the updated state.
// ----------------------------------------------------------------------------
module bcsc_stage_logic (
    input  bcsc_pkg::t_cfg                  i_cfg,
    input  bcsc_pkg::t_ctrl_state           i_state,
    input  logic [bcsc_pkg::MODE_W-1:0]     i_mode,
    input  logic [bcsc_pkg::VOLT_W-1:0]     i_voltage,
    input  logic [bcsc_pkg::MS_W-1:0]       i_elapsed_ms,
    output bcsc_pkg::t_ctrl_state           o_state
);

    logic [bcsc_pkg::CUR_W-1:0]  w_cur_dn;
    logic [bcsc_pkg::CUR_W-1:0]  w_cur_up;
    logic [bcsc_pkg::TIME_W-1:0] w_bal_age;
    logic                        w_eval;
    bcsc_pkg::t_stage            w_stage_nx;

    // Saturating one-step current changes
    assign w_cur_dn  = (i_state.current == '0) ? '0 : i_state.current - 1'b1;
    assign w_cur_up  = (i_state.current == '1) ? '1 : i_state.current + 1'b1;
    assign w_bal_age = i_state.time_ms - i_state.bal_start;
    assign w_eval    = (i_mode == bcsc_pkg::MODE_EVAL);

    // Next stage
    always_comb begin
        w_stage_nx = i_state.stage;
        case (i_mode)
            bcsc_pkg::MODE_ON:   w_stage_nx = bcsc_pkg::ST_READY;
            bcsc_pkg::MODE_OFF:  w_stage_nx = bcsc_pkg::ST_OFF;
            bcsc_pkg::MODE_FULL: w_stage_nx = bcsc_pkg::ST_BAL;
            default: ;
        endcase
        if (w_eval) begin
            unique case (i_state.stage)
                bcsc_pkg::ST_READY: begin
                    if (i_voltage < i_cfg.pre_thr) begin
                        w_stage_nx = bcsc_pkg::ST_PRE;
                    end else if (i_voltage < i_cfg.fast_thr) begin
                        w_stage_nx = bcsc_pkg::ST_FAST;
                    end else if (i_voltage < i_cfg.cv_thr) begin
                        w_stage_nx = bcsc_pkg::ST_NORMAL;
                    end else begin
                        w_stage_nx = bcsc_pkg::ST_CV;
                    end
                end
                bcsc_pkg::ST_PRE: begin
                    if (i_voltage > i_cfg.pre_thr) w_stage_nx = bcsc_pkg::ST_FAST;
                end
                bcsc_pkg::ST_FAST: begin
                    if (i_voltage > i_cfg.fast_thr) w_stage_nx = bcsc_pkg::ST_NORMAL;
                end
                bcsc_pkg::ST_NORMAL: begin
                    if (i_voltage > i_cfg.cv_thr) w_stage_nx = bcsc_pkg::ST_CV;
                end
                bcsc_pkg::ST_BAL: begin
                    if (w_bal_age > i_cfg.bal_dur) w_stage_nx = bcsc_pkg::ST_MAINT;
                end
                default: ;
            endcase
        end
    end

    // Current, clock and balancing start
    always_comb begin
        o_state.stage     = w_stage_nx;
        o_state.current   = i_state.current;
        o_state.time_ms   = i_state.time_ms;
        o_state.bal_start = i_state.bal_start;
        case (i_mode)
            bcsc_pkg::MODE_TICK: o_state.time_ms = i_state.time_ms +
                {{(bcsc_pkg::TIME_W-bcsc_pkg::MS_W){1'b0}}, i_elapsed_ms};
            bcsc_pkg::MODE_FULL: o_state.bal_start = i_state.time_ms;
            bcsc_pkg::MODE_HIGH: o_state.current = w_cur_dn;
            default: ;
        endcase
        if (w_eval) begin
            unique case (i_state.stage) inside
                bcsc_pkg::ST_OFF, bcsc_pkg::ST_READY: o_state.current = '0;
                bcsc_pkg::ST_PRE:    o_state.current = i_cfg.pre_cur;
                bcsc_pkg::ST_FAST:   o_state.current = i_cfg.fast_cur;
                bcsc_pkg::ST_NORMAL: o_state.current = i_cfg.norm_cur;
                bcsc_pkg::ST_CV: begin
                    o_state.current = (i_voltage > i_cfg.cv_thr) ? w_cur_dn : w_cur_up;
                end
                bcsc_pkg::ST_BAL:    o_state.current = i_cfg.bal_cur;
                default: ;
            endcase
        end
    end

endmodule

// ===== design/battery_charge_stage_controller_unit.sv =====
// ----------------------------------------------------------------------------
// battery_charge_stage_controller_unit: multi-stage charger controller
// Takes one event per transaction and returns the commanded current and
// stage after it.
//
//   Channel   Direction  Handshake           Payload
//   input     in         i_valid / o_stall   i_mode, i_voltage, i_elapsed_ms
//   result    out        o_valid / i_stall   o_current, o_stage
//   config    in         APB psel/penable    paddr, pwdata, prdata
//
// One transaction a cycle is sustained while the result is not stalled; each
// result passes through the input register, then the state/result register.
// The state registers double as the result register and are only updated
// when the result register is empty or its result moves out, so a stalled
// result holds.
// Reset is synchronous and active low; it restores the register defaults,
// stage off, current zero and clock zero. No initialisation pass follows.
// o_stall rises only when the input register is full and the result is stalled.
// ----------------------------------------------------------------------------
module battery_charge_stage_controller_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input transactions
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bcsc_pkg::MODE_W-1:0]   i_mode,
    input  logic [bcsc_pkg::VOLT_W-1:0]   i_voltage,
    input  logic [bcsc_pkg::MS_W-1:0]     i_elapsed_ms,
    // Result transactions
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bcsc_pkg::CUR_W-1:0]    o_current,
    output logic [2:0]                    o_stage,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bcsc_pkg::APB_AW-1:0]   paddr,
    input  logic [bcsc_pkg::APB_DW-1:0]   pwdata,
    output logic [bcsc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    bcsc_pkg::t_cfg                   w_cfg;
    bcsc_pkg::t_ctrl_state            r_state;
    bcsc_pkg::t_ctrl_state            n_state;
    logic                             r_in_valid;
    logic [bcsc_pkg::MODE_W-1:0]      r_mode;
    logic [bcsc_pkg::VOLT_W-1:0]      r_voltage;
    logic [bcsc_pkg::MS_W-1:0]        r_elapsed_ms;
    logic                             r_out_valid;
    logic                             w_out_free;
    logic                             w_adv;
    logic                             w_in_load;

    bcsc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bcsc_stage_logic u_logic (
        .i_cfg        (w_cfg),
        .i_state      (r_state),
        .i_mode       (r_mode),
        .i_voltage    (r_voltage),
        .i_elapsed_ms (r_elapsed_ms),
        .o_state      (n_state)
    );

    // Flow control between the two register stages
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;
    assign w_in_load  = i_valid && !o_stall;

    // Hold the accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_load) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load) begin
            r_mode       <= i_mode;
            r_voltage    <= i_voltage;
            r_elapsed_ms <= i_elapsed_ms;
        end
    end

    // Advance the controller state, which is also the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.stage     <= bcsc_pkg::ST_OFF;
            r_state.current   <= '0;
            r_state.time_ms   <= '0;
            r_state.bal_start <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (w_adv) begin
                r_state <= n_state;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_current = r_state.current;
    assign o_stage   = r_state.stage;

    // Stall towards the source only with a full input register
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid)
        else $error("input stall raised with empty input register");

    // A held item is never dropped while the result is stalled
    a_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_mode)))
        else $error("pending transaction lost");

    // Switch on lands in ready
    a_switch_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_mode == bcsc_pkg::MODE_ON) |=> (o_stage == bcsc_pkg::ST_READY))
        else $error("switch on did not give ready");

    // A tick leaves stage and current alone
    a_tick_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_mode == bcsc_pkg::MODE_TICK) |=>
        ($stable(o_current) && $stable(o_stage)))
        else $error("tick changed current or stage");

    // Result state only moves with a new result
    a_state_moves_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> ($stable(o_current) && $stable(o_stage)))
        else $error("stalled result changed");

endmodule
